// ===== src/caeb_pkg.sv =====
// ----------------------------------------------------------------------------
// caeb_pkg
// Shared types and constants of the CsI alpha energy bisection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package caeb_pkg;

  // Register indexes on the configuration port
  localparam logic [7:0] CFG_LIGHT_GAIN      = 8'd0;
  localparam logic [7:0] CFG_QUENCH_FACTOR   = 8'd1;
  localparam logic [7:0] CFG_CHANNEL_OFFSET  = 8'd2;
  localparam logic [7:0] CFG_MATCH_TOLERANCE = 8'd3;

  // Register reset values
  localparam logic [23:0] LIGHT_GAIN_RST      = 24'd819200;
  localparam logic [23:0] QUENCH_FACTOR_RST   = 24'd943718;
  localparam logic [23:0] CHANNEL_OFFSET_RST  = 24'd0;
  localparam logic [7:0]  MATCH_TOLERANCE_RST = 8'd1;

  // Curve constants
  localparam int          ENERGY_MAX_MEV = 200;
  localparam logic [29:0] LN2_Q30        = 30'd744261118;
  localparam int          FRAC_STEPS     = 30;
  localparam int          STEP_CW        = $clog2(FRAC_STEPS);

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SMALL = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_NO_CONV   = 2'd3
  } status_t;

  // Energy selection for a curve evaluation
  typedef enum logic [1:0] {
    ES_ZERO = 2'd0,
    ES_HIGH = 2'd1,
    ES_MID  = 2'd2
  } esel_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_START    = 4'd2,
    OP_NORM     = 4'd3,
    OP_BYPASS   = 4'd4,
    OP_DIV_INIT = 4'd5,
    OP_DIV      = 4'd6,
    OP_SQR      = 4'd7,
    OP_LNA      = 4'd8,
    OP_LNB      = 4'd9,
    OP_SMUL     = 4'd10,
    OP_QSUB     = 4'd11,
    OP_GAIN     = 4'd12,
    OP_FVAL     = 4'd13,
    OP_STEP     = 4'd14,
    OP_EMIT     = 4'd15
  } op_t;

  typedef struct packed {
    op_t     op;
    esel_t   esel;
    status_t res;
  } cmd_t;

  typedef struct packed {
    logic byp;
    logic norm_done;
    logic f_gt;
    logic f_lt;
    logic match;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/caeb_dp.sv =====
// ----------------------------------------------------------------------------
// caeb_dp
// Datapath: configuration registers, bisection bounds and a sequential
// evaluator of the light-output curve (shift search, restoring divider,
// squaring log2, multiplies).
// ----------------------------------------------------------------------------
`default_nettype none

module caeb_dp import caeb_pkg::*; #(
  parameter int ENERGY_FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic [23:0] in_channel,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic [23:0]      out_energy,
  output logic [1:0]       out_status
);

  localparam int EW  = ENERGY_FRACTION_BITS + 8;
  localparam int ESH = 24 - ENERGY_FRACTION_BITS;
  localparam logic [EW-1:0] E_MAX      = EW'(ENERGY_MAX_MEV) << ENERGY_FRACTION_BITS;
  localparam logic [56:0]   ROUND_HALF = 57'd1 << 27;

  logic [23:0]        gain_r;
  logic [23:0]        quench_r;
  logic signed [23:0] offset_r;
  logic [7:0]         tol_r;

  logic [23:0]        ch_r;
  logic [EW-1:0]      lo_r;
  logic [EW-1:0]      hi_r;
  logic [EW-1:0]      e_r;
  logic [31:0]        e24_r;
  logic [32:0]        num_r;
  logic [33:0]        dsh_r;
  logic [5:0]         k_r;
  logic [33:0]        rem_r;
  logic [30:0]        m_r;
  logic [29:0]        frac_r;
  logic [35:0]        kl_r;
  logic [29:0]        fl_r;
  logic [35:0]        ln_r;
  logic [37:0]        sa_r;
  logic [31:0]        sb_r;
  logic [31:0]        q_r;
  logic [56:0]        prod_r;
  logic signed [31:0] f_r;
  logic [23:0]        out_energy_r;
  logic [1:0]         out_status_r;

  logic [31:0]        t24;
  logic [EW:0]        mid_sum;
  logic [EW-1:0]      mid;
  logic [EW-1:0]      e_sel;
  logic [31:0]        e24_sel;
  logic [33:0]        dsh2;
  logic               norm_more;
  logic [33:0]        rem2;
  logic               rem_ge;
  logic [61:0]        sq_full;
  logic [31:0]        sq;
  logic [59:0]        fl_full;
  logic [61:0]        sb_full;
  logic [38:0]        s_sum;
  logic signed [32:0] diff;
  logic signed [32:0] absd;

  // Select the energy under evaluation
  always_comb begin
    t24     = {quench_r, 8'h00};
    mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
    mid     = mid_sum[EW:1];
    unique case (cmd.esel)
      ES_ZERO: e_sel = '0;
      ES_HIGH: e_sel = hi_r;
      ES_MID:  e_sel = mid;
      default: e_sel = '0;
    endcase
    e24_sel = 32'(e_sel) << ESH;
  end

  // Step logic of the shift search, divider, squaring log and multiplies
  always_comb begin
    dsh2      = {dsh_r[32:0], 1'b0};
    norm_more = dsh2 <= {1'b0, num_r};
    rem2      = {rem_r[32:0], 1'b0};
    rem_ge    = rem2 >= dsh_r;
    sq_full   = 62'(m_r) * 62'(m_r);
    sq        = sq_full[61:30];
    fl_full   = 60'(frac_r) * 60'(LN2_Q30);
    sb_full   = 62'(t24) * 62'(ln_r[29:0]);
    s_sum     = 39'(sa_r) + 39'(sb_r);
  end

  // Compare the curve value with the channel
  always_comb begin
    diff = 33'(f_r) - $signed({9'b0, ch_r});
    absd = (diff < 0) ? -diff : diff;
    sts.byp       = (quench_r == '0) || (e24_r == '0);
    sts.norm_done = !norm_more;
    sts.f_gt      = diff > 0;
    sts.f_lt      = diff < 0;
    sts.match     = absd < $signed({25'b0, tol_r});
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= LIGHT_GAIN_RST;
      quench_r <= QUENCH_FACTOR_RST;
      offset_r <= CHANNEL_OFFSET_RST;
      tol_r    <= MATCH_TOLERANCE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LIGHT_GAIN:      gain_r   <= cfg_data;
        CFG_QUENCH_FACTOR:   quench_r <= cfg_data;
        CFG_CHANNEL_OFFSET:  offset_r <= cfg_data;
        CFG_MATCH_TOLERANCE: tol_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Advance the datapath on each command
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ch_r <= in_channel;
        lo_r <= '0;
        hi_r <= E_MAX;
      end
      OP_START: begin
        e_r   <= e_sel;
        e24_r <= e24_sel;
        num_r <= 33'(t24) + 33'(e24_sel);
        dsh_r <= 34'(t24);
        k_r   <= '0;
      end
      OP_NORM: begin
        if (norm_more) begin
          dsh_r <= dsh2;
          k_r   <= k_r + 6'd1;
        end
      end
      OP_BYPASS: q_r <= e24_r;
      OP_DIV_INIT: begin
        rem_r  <= 34'(num_r) - dsh_r;
        m_r    <= 31'd1;
        frac_r <= '0;
      end
      OP_DIV: begin
        rem_r <= rem_ge ? rem2 - dsh_r : rem2;
        m_r   <= {m_r[29:0], rem_ge};
      end
      OP_SQR: begin
        m_r    <= sq[31] ? sq[31:1] : sq[30:0];
        frac_r <= {frac_r[28:0], sq[31]};
      end
      OP_LNA: begin
        kl_r <= 36'(k_r) * 36'(LN2_Q30);
        fl_r <= fl_full[59:30];
      end
      OP_LNB: ln_r <= kl_r + 36'(fl_r);
      OP_SMUL: begin
        sa_r <= 38'(t24) * 38'(ln_r[35:30]);
        sb_r <= sb_full[61:30];
      end
      OP_QSUB: q_r <= (s_sum >= 39'(e24_r)) ? '0 : 32'(39'(e24_r) - s_sum);
      OP_GAIN: prod_r <= 57'(gain_r) * 57'(q_r) + ROUND_HALF;
      OP_FVAL: f_r <= $signed({3'b0, prod_r[56:28]}) + 32'(offset_r);
      OP_STEP: begin
        if (sts.f_lt) begin
          lo_r <= e_r;
        end else begin
          hi_r <= e_r;
        end
      end
      OP_EMIT: begin
        out_energy_r <= (cmd.res == ST_OK) ? 24'(e_r) : '0;
        out_status_r <= cmd.res;
      end
      default: ;
    endcase
  end

  assign out_energy = out_energy_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// ===== src/caeb_ctrl.sv =====
// ----------------------------------------------------------------------------
// caeb_ctrl
// Controller: sequences bound checks, bisection steps and the sub-steps of
// each curve evaluation, and owns the channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module caeb_ctrl import caeb_pkg::*; #(
  parameter int ITERATIONS = 24
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam int IW = $clog2(ITERATIONS);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_START  = 13'b0000000000010,
    S_NORM   = 13'b0000000000100,
    S_DIV    = 13'b0000000001000,
    S_SQR    = 13'b0000000010000,
    S_LNA    = 13'b0000000100000,
    S_LNB    = 13'b0000001000000,
    S_SMUL   = 13'b0000010000000,
    S_QSUB   = 13'b0000100000000,
    S_GAIN   = 13'b0001000000000,
    S_FVAL   = 13'b0010000000000,
    S_DECIDE = 13'b0100000000000,
    S_FINISH = 13'b1000000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_LOW  = 3'b001,
    PH_HIGH = 3'b010,
    PH_BIS  = 3'b100
  } phase_t;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [STEP_CW-1:0]   cnt_r, cnt_nxt;
  logic [IW-1:0]        iter_r, iter_nxt;
  status_t              res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Next-state and command decode
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    iter_nxt      = iter_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.res       = res_r;
    unique case (phase_r)
      PH_LOW:  cmd.esel = ES_ZERO;
      PH_HIGH: cmd.esel = ES_HIGH;
      PH_BIS:  cmd.esel = ES_MID;
      default: cmd.esel = ES_ZERO;
    endcase

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          phase_nxt = PH_LOW;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.op    = OP_START;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        priority if (sts.byp) begin
          cmd.op    = OP_BYPASS;
          state_nxt = S_GAIN;
        end else if (sts.norm_done) begin
          cmd.op    = OP_DIV_INIT;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == STEP_CW'(FRAC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQR: begin
        cmd.op = OP_SQR;
        if (cnt_r == STEP_CW'(FRAC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_LNA;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LNA: begin
        cmd.op    = OP_LNA;
        state_nxt = S_LNB;
      end
      S_LNB: begin
        cmd.op    = OP_LNB;
        state_nxt = S_SMUL;
      end
      S_SMUL: begin
        cmd.op    = OP_SMUL;
        state_nxt = S_QSUB;
      end
      S_QSUB: begin
        cmd.op    = OP_QSUB;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        cmd.op    = OP_GAIN;
        state_nxt = S_FVAL;
      end
      S_FVAL: begin
        cmd.op    = OP_FVAL;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (phase_r)
          PH_LOW: begin
            if (sts.f_gt) begin
              res_nxt   = ST_TOO_SMALL;
              state_nxt = S_FINISH;
            end else begin
              phase_nxt = PH_HIGH;
              state_nxt = S_START;
            end
          end
          PH_HIGH: begin
            if (sts.f_lt) begin
              res_nxt   = ST_TOO_LARGE;
              state_nxt = S_FINISH;
            end else begin
              phase_nxt = PH_BIS;
              iter_nxt  = '0;
              state_nxt = S_START;
            end
          end
          PH_BIS: begin
            priority if (sts.match) begin
              res_nxt   = ST_OK;
              state_nxt = S_FINISH;
            end else if (iter_r == IW'(ITERATIONS - 1)) begin
              res_nxt   = ST_NO_CONV;
              state_nxt = S_FINISH;
            end else begin
              cmd.op    = OP_STEP;
              iter_nxt  = iter_r + 1'b1;
              state_nxt = S_START;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LOW;
      cnt_r       <= '0;
      iter_r      <= '0;
      res_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      iter_r      <= iter_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/csi_alpha_energy_bisection_unit.sv =====
// ----------------------------------------------------------------------------
// csi_alpha_energy_bisection_unit
// Alpha-particle energy from a CsI channel by bisection of the light-output
// curve f(E) = a0*(E - t*ln(1+E/t)) + a2.
// ----------------------------------------------------------------------------
// One channel transaction in, one result out. The block works on one item at
// a time: each curve evaluation runs a one-bit-per-cycle shift search for k
// (0..23), the integer log2 of (t+E)/t, followed by a restoring divider and
// 30 squaring steps of the log unit; with zero quench or zero energy it
// bypasses the shift search, divider and log unit. An item runs two bound
// evaluations (the one at zero energy always takes the bypass) and up to
// ITERATIONS bisection evaluations. A finished result waits in the output
// register; the next item is taken once that result has been handed to the
// output register. Configuration writes are accepted in every cycle and must
// be issued while idle.
`default_nettype none

module csi_alpha_energy_bisection_unit import caeb_pkg::*; #(
  parameter int ITERATIONS           = 24,
  parameter int ENERGY_FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] in_channel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [23:0]      out_energy,
  output logic [1:0]       out_status
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  caeb_ctrl #(
    .ITERATIONS(ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  caeb_dp #(
    .ENERGY_FRACTION_BITS(ENERGY_FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_channel(in_channel),
    .cmd       (cmd),
    .sts       (sts),
    .out_energy(out_energy),
    .out_status(out_status)
  );

  // A failed result carries zero energy
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_energy == '0))
    else $error("nonzero energy on failed result");

  // Block goes busy after taking a channel
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

endmodule

`default_nettype wire

// ===== test/csi_alpha_energy_bisection_unit_test.sv =====
// ----------------------------------------------------------------------------
// csi_alpha_energy_bisection_unit_test
// Checks every channel result of the bisection unit against a local curve
// predictor, over directed bound and special cases and random channels under
// several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module csi_alpha_energy_bisection_unit_test import caeb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_STEPS  = 24;
  localparam int ERR_REPORT = 10;

  typedef struct packed {
    logic [23:0] energy;
    status_t     status;
  } solution_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [23:0] in_channel;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] out_energy;
  logic [1:0]  out_status;

  // Local copy of the register file
  logic [23:0]        gain_q;
  logic [23:0]        quench_q;
  logic signed [23:0] offset_q;
  logic [7:0]         tol_q;

  solution_t solutions_due[$];
  int        mismatch_cnt;
  int        hold_cycles;
  bit        calm;

  csi_alpha_energy_bisection_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_channel (in_channel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_energy (out_energy),
    .out_status (out_status)
  );

  // Clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ln(num/den) in Q.30, log2 by shifts, mantissa squaring, scaled by ln2
  function automatic logic [63:0] ln_q30(logic [63:0] num, logic [63:0] den);
    int unsigned k;
    logic [63:0] mant;
    logic [63:0] frac;
    k = 0;
    frac = 0;
    while (k < 40 && (den << (k + 1)) <= num) k++;
    mant = (num << 30) / (den << k);
    for (int i = 0; i < 30; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        frac[0] = 1'b1;
      end
    end
    return 64'(k) * LN2_Q30 + ((frac * LN2_Q30) >> 30);
  endfunction

  // Light output in signed Q.8 channels for a Q8.16 energy code
  function automatic longint light_curve(logic [63:0] ecode);
    logic [63:0] e24;
    logic [63:0] t24;
    logic [63:0] q;
    logic [63:0] lnv;
    logic [63:0] s;
    e24 = ecode << 8;
    t24 = 64'(quench_q) << 8;
    q = e24;
    if (t24 != 0 && e24 != 0) begin
      lnv = ln_q30(t24 + e24, t24);
      s = t24 * (lnv >> 30) + ((t24 * (lnv & 64'h3FFF_FFFF)) >> 30);
      q = (s >= e24) ? 64'd0 : e24 - s;
    end
    return longint'((64'(gain_q) * q + (64'd1 << 27)) >> 28) + longint'(offset_q);
  endfunction

  // Solve the curve for one channel by bisection over 0..200 MeV
  function automatic solution_t solve_energy(logic [23:0] chan);
    solution_t   sol;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    longint      f;
    longint      d;
    longint      ch;
    ch = longint'({40'd0, chan});
    lo = 0;
    hi = 64'(ENERGY_MAX_MEV) << 16;
    sol.energy = '0;
    sol.status = ST_NO_CONV;
    if (light_curve(lo) > ch) begin
      sol.status = ST_TOO_SMALL;
    end else if (light_curve(hi) < ch) begin
      sol.status = ST_TOO_LARGE;
    end else begin
      for (int i = 0; i < NUM_STEPS; i++) begin
        mid = (lo + hi) >> 1;
        f = light_curve(mid);
        d = (f < ch) ? ch - f : f - ch;
        if (d < longint'(tol_q)) begin
          sol.energy = mid[23:0];
          sol.status = ST_OK;
          break;
        end
        if (f < ch) lo = mid;
        else hi = mid;
      end
    end
    return sol;
  endfunction

  // Predict a result on every accepted channel transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      solutions_due = {solutions_due, solve_energy(in_channel)};
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    solution_t exp_sol;
    if (rst_n && out_valid && out_ready) begin
      if (solutions_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ERR_REPORT)
          $display("unexpected result energy=%0d status=%0d", out_energy, out_status);
      end else begin
        exp_sol = solutions_due.pop_front();
        if (out_energy !== exp_sol.energy || out_status !== exp_sol.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ERR_REPORT)
            $display("result mismatch: expected energy=%0d status=%0d, got energy=%0d status=%0d",
                     exp_sol.energy, exp_sol.status, out_energy, out_status);
        end
      end
    end
  end

  // Receiver: random stall bursts, long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        while (hold_cycles > 0) begin
          @(negedge clk);
          hold_cycles--;
        end
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Send one channel; valid stays high after acceptance, or drops for a random gap
  task automatic send_channel(logic [23:0] chan);
    @(negedge clk);
    in_valid = 1'b1;
    in_channel = chan;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 2) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
    end
  endtask

  // Wait until all results are in, then leave a short idle gap
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (solutions_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [23:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      CFG_LIGHT_GAIN:      gain_q = value;
      CFG_QUENCH_FACTOR:   quench_q = value;
      CFG_CHANNEL_OFFSET:  offset_q = value;
      CFG_MATCH_TOLERANCE: tol_q = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_curve(logic [23:0] gain, logic [23:0] quench, logic [23:0] offset,
                           logic [7:0] tol);
    drain();
    write_reg(CFG_LIGHT_GAIN, gain);
    write_reg(CFG_QUENCH_FACTOR, quench);
    write_reg(CFG_CHANNEL_OFFSET, offset);
    write_reg(CFG_MATCH_TOLERANCE, {16'd0, tol});
  endtask

  // Channel inside the curve range, else fully random
  function automatic logic [23:0] pick_channel(int wild_pct);
    longint lo_ch;
    longint hi_ch;
    lo_ch = light_curve(0);
    hi_ch = light_curve(64'(ENERGY_MAX_MEV) << 16);
    if (lo_ch < 0) lo_ch = 0;
    if (hi_ch > longint'(24'hFFFFFF)) hi_ch = longint'(24'hFFFFFF);
    if ($urandom_range(1, 100) <= wild_pct || hi_ch <= lo_ch) return 24'($urandom);
    return 24'(lo_ch + longint'($urandom_range(0, 32'(hi_ch - lo_ch))));
  endfunction

  // Bounds and the edges of the channel field
  task automatic test_bounds();
    longint lo_ch;
    longint hi_ch;
    lo_ch = light_curve(0);
    hi_ch = light_curve(64'(ENERGY_MAX_MEV) << 16);
    send_channel(24'd0);
    send_channel(24'hFFFFFF);
    send_channel(24'(lo_ch));
    send_channel(24'(hi_ch));
    send_channel(24'(hi_ch + 1));
    send_channel(24'((lo_ch + hi_ch) / 2));
    send_channel(24'h555555);
    send_channel(24'hAAAAAA);
  endtask

  // Linear curve with zero quench
  task automatic test_zero_quench();
    set_curve(24'd819200, 24'd0, 24'd0, 8'd1);
    send_channel(24'd0);
    send_channel(24'd100000);
    send_channel(24'd4000000);
  endtask

  // Flat curve with zero gain
  task automatic test_zero_gain();
    set_curve(24'd0, 24'd943718, 24'd5000, 8'd4);
    send_channel(24'd5000);
    send_channel(24'd4999);
    send_channel(24'd5001);
  endtask

  // Zero tolerance never matches
  task automatic test_zero_tolerance();
    set_curve(24'd819200, 24'd943718, 24'd0, 8'd0);
    send_channel(24'd200000);
    send_channel(24'd0);
  endtask

  // Register extremes, then an ignored register index
  task automatic test_register_extremes();
    set_curve(24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 8'hFF);
    send_channel(24'hFFFFFF);
    send_channel(pick_channel(0));
    set_curve(24'd1, 24'd1, 24'h800000, 8'hFF);
    send_channel(24'd0);
    send_channel(pick_channel(0));
    set_curve(24'd819200, 24'd943718, 24'd0, 8'd1);
    write_reg(8'd7, 24'hFFFFFF);
    send_channel(24'd300000);
  endtask

  // Hold the receiver off while channels keep coming
  task automatic test_backpressure();
    hold_cycles = 12000;
    repeat (6) send_channel(pick_channel(10));
    drain();
  endtask

  // Random channels under random curves
  task automatic test_random_channels(int num_sets, int per_set);
    for (int s = 0; s < num_sets; s++) begin
      if ($urandom_range(0, 3) == 0)
        set_curve(24'($urandom), 24'($urandom_range(0, 2000000)), 24'($urandom),
                  8'($urandom_range(0, 255)));
      else
        set_curve(24'($urandom_range(100000, 3000000)), 24'($urandom_range(0, 3000000)),
                  24'($urandom_range(0, 4000)), 8'($urandom_range(1, 64)));
      for (int i = 0; i < per_set; i++) send_channel(pick_channel(10));
      if (s == num_sets / 2) drain();
    end
  endtask

  // Run limit
  initial begin
    #400ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_channel = '0;
    mismatch_cnt = 0;
    hold_cycles = 0;
    calm = 1'b0;
    gain_q = LIGHT_GAIN_RST;
    quench_q = QUENCH_FACTOR_RST;
    offset_q = CHANNEL_OFFSET_RST;
    tol_q = MATCH_TOLERANCE_RST;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_bounds();
    test_zero_quench();
    test_zero_gain();
    test_zero_tolerance();
    test_register_extremes();
    test_backpressure();
    test_random_channels(16, 50);
    calm = 1'b1;
    test_random_channels(4, 40);
    drain();
    repeat (100) @(negedge clk);

    if (mismatch_cnt == 0 && solutions_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/caeb_pkg.sv
src/caeb_dp.sv
src/caeb_ctrl.sv
src/csi_alpha_energy_bisection_unit.sv
test/csi_alpha_energy_bisection_unit_test.sv
